@@ src/rampm_pkg.sv @@
package rampm_pkg;

  // Largest brush size that a register write may set.
  localparam int unsigned MAX_NIB_SIZE = 255;

  localparam logic [7:0]  NIB_RESET   = 8'd16;
  localparam logic [7:0]  FULL_ALPHA  = 8'd150;
  localparam logic [14:0] SCALE_SQ    = 15'd22500;

  // Register index, taken from the word address of the configuration port.
  localparam logic CFG_NIB_SIZE = 1'b0;

  // Sixteen square root iterations, two per stage.
  localparam int unsigned SQ_STAGES  = 8;
  // Eight quotient bits, two per stage.
  localparam int unsigned DIV_STAGES = 4;
  localparam int unsigned DIV_BITS   = 8;

  // Values that ride along with a pixel while its distance is worked out.
  typedef struct packed {
    logic [6:0]  half;
    logic [14:0] lim;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } rampm_side_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] root;
  } sq_t;

  typedef struct packed {
    logic [15:0] rem;
    logic [7:0]  quo;
    logic        sat;
    logic        hz;
  } dv_t;

  // Test bit of square root iteration it, counting from the top.
  function automatic logic [31:0] sq_bit(input int unsigned it);
    return 32'h4000_0000 >> (2 * it);
  endfunction

  function automatic sq_t sqrt_step(input sq_t s, input logic [31:0] bit_v);
    sq_t         r;
    logic [32:0] trial;
    trial = {1'b0, s.root} + {1'b0, bit_v};
    r     = s;
    if ({1'b0, s.rem} >= trial) begin
      r.rem  = 32'({1'b0, s.rem} - trial);
      r.root = (s.root >> 1) + bit_v;
    end else begin
      r.root = s.root >> 1;
    end
    return r;
  endfunction

  function automatic dv_t div_step(input dv_t d, input logic [6:0] half, input logic [2:0] j);
    dv_t         r;
    logic [15:0] dvs;
    dvs = 16'(half) << j;
    r   = d;
    if (d.rem >= dvs) begin
      r.rem    = d.rem - dvs;
      r.quo[j] = 1'b1;
    end
    return r;
  endfunction

endpackage

@@ src/rampm_sqrt.sv @@
module rampm_sqrt (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [31:0]           in_x,
  input  rampm_pkg::rampm_side_t in_side,
  output logic                  out_valid,
  output logic [15:0]           out_root,
  output rampm_pkg::rampm_side_t out_side
);
  import rampm_pkg::*;

  sq_t                   st_r [SQ_STAGES];
  rampm_side_t           sd_r [SQ_STAGES];
  logic [SQ_STAGES-1:0]  vld_r;

  sq_t                   st_in [SQ_STAGES];
  rampm_side_t           sd_in [SQ_STAGES];
  logic [SQ_STAGES-1:0]  vld_nxt;

  always_comb begin
    st_in[0] = '{rem: in_x, root: 32'd0};
    sd_in[0] = in_side;
    for (int k = 1; k < SQ_STAGES; k++) begin
      st_in[k] = st_r[k-1];
      sd_in[k] = sd_r[k-1];
    end
    vld_nxt = {vld_r[SQ_STAGES-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // Each stage runs two iterations of the digit-by-digit root.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQ_STAGES; k++) begin
        st_r[k] <= sqrt_step(sqrt_step(st_in[k], sq_bit(2 * k)), sq_bit(2 * k + 1));
        sd_r[k] <= sd_in[k];
      end
    end
  end

  assign out_valid = vld_r[SQ_STAGES-1];
  assign out_root  = st_r[SQ_STAGES-1].root[15:0];
  assign out_side  = sd_r[SQ_STAGES-1];

endmodule

@@ src/rampm_div.sv @@
module rampm_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [15:0]           in_root,
  input  rampm_pkg::rampm_side_t in_side,
  output logic                  out_valid,
  output rampm_pkg::dv_t        out_dv,
  output rampm_pkg::rampm_side_t out_side
);
  import rampm_pkg::*;

  dv_t                   dv_r [DIV_STAGES];
  rampm_side_t           sd_r [DIV_STAGES];
  logic [DIV_STAGES-1:0] vld_r;

  dv_t                   dv_in [DIV_STAGES];
  rampm_side_t           sd_in [DIV_STAGES];
  logic [DIV_STAGES-1:0] vld_nxt;

  // A root at or beyond 150 half-steps saturates the distance, so the
  // quotient that remains always fits in eight bits.
  always_comb begin
    dv_in[0].rem = in_root;
    dv_in[0].quo = '0;
    dv_in[0].sat = (in_root >= {1'b0, in_side.lim});
    dv_in[0].hz  = (in_side.half == '0);
    sd_in[0]     = in_side;
    for (int k = 1; k < DIV_STAGES; k++) begin
      dv_in[k] = dv_r[k-1];
      sd_in[k] = sd_r[k-1];
    end
    vld_nxt = {vld_r[DIV_STAGES-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        dv_r[k] <= div_step(div_step(dv_in[k], sd_in[k].half, 3'(DIV_BITS - 1 - 2 * k)),
                            sd_in[k].half, 3'(DIV_BITS - 2 - 2 * k));
        sd_r[k] <= sd_in[k];
      end
    end
  end

  assign out_valid = vld_r[DIV_STAGES-1];
  assign out_dv    = dv_r[DIV_STAGES-1];
  assign out_side  = sd_r[DIV_STAGES-1];

endmodule

@@ src/radial_alpha_mask_premultiply.sv @@
// Throughput: one word per clock cycle; the 18 stages all advance together and
// hold while a finished word waits on the output.
// Reset (rst_n low at a clock edge) empties the pipeline and sets nib_size to 16.
module radial_alpha_mask_premultiply (
  input  logic        clk,
  input  logic        rst_n,
  // Pixel input.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_col,
  input  logic [7:0]  in_row,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_red,
  // Premultiplied pixel output.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_green,
  output logic [7:0]  out_red,
  output logic [7:0]  out_coverage,
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import rampm_pkg::*;

  // The pipeline moves as one piece whenever the output register is free
  // or is being emptied in this cycle. Bubbles travel like any other word,
  // guarded by their valid bits.
  logic en;
  logic out_valid_r;
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // ---------------------------------------------------------------------
  // Configuration register. Only one register exists, at word address 0;
  // writes to any other word are dropped.
  // ---------------------------------------------------------------------
  logic [7:0] nib_r;
  logic [7:0] nib_nxt;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[2] == CFG_NIB_SIZE);
  assign nib_nxt    = (32'(cfg_pwdata[7:0]) > MAX_NIB_SIZE) ? 8'(MAX_NIB_SIZE)
                                                             : cfg_pwdata[7:0];
  assign cfg_prdata = (cfg_paddr[2] == CFG_NIB_SIZE) ? {24'd0, nib_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nib_r <= NIB_RESET;
    end else if (cfg_wr) begin
      nib_r <= nib_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 0: offsets from the center and the saturation limit 150 * half.
  // Configuration must change only while the block is idle; the block does
  // not enforce this. The register is sampled here once per word.
  // ---------------------------------------------------------------------
  logic [6:0]  half;
  logic [7:0]  dx_nxt, dy_nxt;
  rampm_side_t sd0_nxt;
  logic        v0_r;
  logic [7:0]  dx_r, dy_r;
  rampm_side_t sd0_r;

  assign half   = nib_r[7:1];
  assign dx_nxt = (in_col >= {1'b0, half}) ? (in_col - {1'b0, half}) : ({1'b0, half} - in_col);
  assign dy_nxt = (in_row >= {1'b0, half}) ? (in_row - {1'b0, half}) : ({1'b0, half} - in_row);

  always_comb begin
    sd0_nxt.half  = half;
    sd0_nxt.lim   = 15'(half) * 15'(FULL_ALPHA);
    sd0_nxt.blue  = in_blue;
    sd0_nxt.green = in_green;
    sd0_nxt.red   = in_red;
  end

  // Stage 1: squared distance. Stage 2: scaled by 150 squared so that the
  // root comes out in units of 1/150 of a pixel.
  logic [15:0] dx_sq, dy_sq;
  logic        v1_r, v2_r;
  logic [16:0] d2_r;
  logic [31:0] x_r;
  rampm_side_t sd1_r, sd2_r;

  assign dx_sq = dx_r * dx_r;
  assign dy_sq = dy_r * dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r  <= dx_nxt;
      dy_r  <= dy_nxt;
      sd0_r <= sd0_nxt;
      d2_r  <= 17'(dx_sq) + 17'(dy_sq);
      sd1_r <= sd0_r;
      x_r   <= 32'(d2_r) * 32'(SCALE_SQ);
      sd2_r <= sd1_r;
    end
  end

  // ---------------------------------------------------------------------
  // Square root over eight stages, then the division by half over four.
  // ---------------------------------------------------------------------
  logic        vs;
  logic [15:0] root;
  rampm_side_t sds;

  rampm_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v2_r),
    .in_x      (x_r),
    .in_side   (sd2_r),
    .out_valid (vs),
    .out_root  (root),
    .out_side  (sds)
  );

  logic        vd;
  dv_t         dv;
  rampm_side_t sdd;

  rampm_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vs),
    .in_root   (root),
    .in_side   (sds),
    .out_valid (vd),
    .out_dv    (dv),
    .out_side  (sdd)
  );

  // ---------------------------------------------------------------------
  // Alpha, the three color products, and the truncating divide by 255.
  // A zero half (a brush size of zero or one) is fully covered everywhere.
  // ---------------------------------------------------------------------
  logic [7:0]  alpha_nxt;
  logic        va_r, vm_r;
  logic [7:0]  alpha_r, cov_m_r;
  rampm_side_t sda_r;
  logic [15:0] pb_r, pg_r, pr_r;
  logic [16:0] qb, qg, qr;

  always_comb begin
    priority if (dv.hz) begin
      alpha_nxt = FULL_ALPHA;
    end else if (dv.sat) begin
      alpha_nxt = 8'd0;
    end else begin
      alpha_nxt = FULL_ALPHA - dv.quo;
    end
  end

  // floor(p / 255) equals (p + (p >> 8) + 1) >> 8 for every product in range.
  assign qb = 17'(pb_r) + 17'(pb_r[15:8]) + 17'd1;
  assign qg = 17'(pg_r) + 17'(pg_r[15:8]) + 17'd1;
  assign qr = 17'(pr_r) + 17'(pr_r[15:8]) + 17'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      vm_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      va_r        <= vd;
      vm_r        <= va_r;
      out_valid_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      alpha_r      <= alpha_nxt;
      sda_r        <= sdd;
      pb_r         <= sda_r.blue * alpha_r;
      pg_r         <= sda_r.green * alpha_r;
      pr_r         <= sda_r.red * alpha_r;
      cov_m_r      <= alpha_r;
      out_blue     <= qb[15:8];
      out_green    <= qg[15:8];
      out_red      <= qr[15:8];
      out_coverage <= cov_m_r;
    end
  end

  assign out_valid = out_valid_r;

  // ---------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------
  a_cov_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_coverage <= FULL_ALPHA)
    else $error("coverage above full alpha");

  a_color_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_blue <= out_coverage) && (out_green <= out_coverage)
                  && (out_red <= out_coverage))
    else $error("premultiplied color exceeds coverage");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vd && !en) |=> vd && $stable(dv))
    else $error("division result moved during a stall");

  a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
    (vd && !dv.hz && !dv.sat) |-> dv.quo < FULL_ALPHA)
    else $error("unsaturated distance out of range");

endmodule

@@ verif/brush_pixel_sb_pkg.sv @@
`timescale 1ns / 100ps
package brush_pixel_sb_pkg;
  import rampm_pkg::*;

  // One premultiplied pixel as it leaves the block, coverage in the low byte.
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] coverage;
  } shaded_pixel_t;

  class pixel_scoreboard;
    logic [7:0]    nib_size;
    shaded_pixel_t awaited[$];
    int unsigned   errors;

    function new();
      nib_size = NIB_RESET;
      errors   = 0;
    endfunction

    function void write_size(input logic [31:0] value);
      if (32'(value[7:0]) > MAX_NIB_SIZE) begin
        nib_size = 8'(MAX_NIB_SIZE);
      end else begin
        nib_size = value[7:0];
      end
    endfunction

    // Works out the shaded pixel for one accepted word and queues it.
    function void note_pixel(input logic [7:0] col, input logic [7:0] row,
                             input logic [7:0] blue, input logic [7:0] green,
                             input logic [7:0] red);
      shaded_pixel_t px;
      logic [7:0]    half;
      logic [7:0]    dx;
      logic [7:0]    dy;
      logic [63:0]   area;
      logic [63:0]   root;
      logic [63:0]   trial;
      logic [63:0]   span;
      logic [7:0]    alpha;
      int            b;
      half = nib_size >> 1;
      dx   = (col >= half) ? col - half : half - col;
      dy   = (row >= half) ? row - half : half - row;
      span = 0;
      if (half != 0) begin
        area = (64'(dx) * 64'(dx) + 64'(dy) * 64'(dy)) * 64'(SCALE_SQ);
        // Floor square root, settled one bit at a time from the top.
        root = 0;
        for (b = 31; b >= 0; b--) begin
          trial = root | (64'd1 << b);
          if (trial * trial <= area) root = trial;
        end
        span = root / 64'(half);
      end
      alpha       = (span >= 64'(FULL_ALPHA)) ? 8'd0 : 8'(64'(FULL_ALPHA) - span);
      px.blue     = 8'((32'(blue) * 32'(alpha)) / 32'd255);
      px.green    = 8'((32'(green) * 32'(alpha)) / 32'd255);
      px.red      = 8'((32'(red) * 32'(alpha)) / 32'd255);
      px.coverage = alpha;
      awaited.push_back(px);
    endfunction

    function void check_pixel(input shaded_pixel_t got);
      logic [3:0][7:0] want_b;
      logic [3:0][7:0] got_b;
      string           field_name [4];
      int              i;
      field_name = '{"coverage", "red", "green", "blue"};
      if (awaited.size() == 0) begin
        $display("%0t ns: pixel with nothing awaited, actual %h", $time, got);
        errors++;
        return;
      end
      want_b = awaited.pop_front();
      got_b  = got;
      for (i = 0; i < 4; i++) begin
        if (got_b[i] !== want_b[i]) begin
          $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                   $time, field_name[i], want_b[i], got_b[i]);
          errors++;
        end
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

endpackage

@@ verif/tb_radial_alpha_mask_premultiply.sv @@
`timescale 1ns / 100ps
module tb_radial_alpha_mask_premultiply;
  import rampm_pkg::*;
  import brush_pixel_sb_pkg::*;

  // Byte addresses of the brush size register and of an unused register slot.
  localparam logic [2:0] NIB_SIZE_ADDR = {CFG_NIB_SIZE, 2'b00};
  localparam logic [2:0] SPARE_ADDR    = {~CFG_NIB_SIZE, 2'b00};

  // The pipeline is 18 stages deep; the drain wait is longer to cover any slack.
  localparam int DRAIN_CYCLES = 24;
  // Receiver hold-off, long enough to fill the pipeline and stall the input.
  localparam int HOLD_CYCLES  = 60;
  // Cycles without any word moved on any port before the run is abandoned.
  localparam int STALL_LIMIT  = 2000;
  localparam int PHASE_WORDS  = 78;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_col;
  logic [7:0]  in_row;
  logic [7:0]  in_blue;
  logic [7:0]  in_green;
  logic [7:0]  in_red;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_blue;
  logic [7:0]  out_green;
  logic [7:0]  out_red;
  logic [7:0]  out_coverage;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Random gaps on both channels are allowed while this is set.
  bit gaps_enabled = 1'b1;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit hold_off     = 1'b0;

  pixel_scoreboard shade_sb;

  radial_alpha_mask_premultiply uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_col       (in_col),
    .in_row       (in_row),
    .in_blue      (in_blue),
    .in_green     (in_green),
    .in_red       (in_red),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_blue     (out_blue),
    .out_green    (out_green),
    .out_red      (out_red),
    .out_coverage (out_coverage),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Color bytes lean toward the extremes now and then so that full and empty
  // channels show up often in the products.
  function automatic logic [7:0] pick_shade();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Offers one pixel word and waits until the block takes it. All inputs move
  // on the falling edge; acceptance is judged at the rising edge. Valid stays
  // high after acceptance, so the caller either offers the next word at the
  // next falling edge or lowers valid there.
  task automatic send_pixel(input logic [7:0] col, input logic [7:0] row,
                            input logic [7:0] blue, input logic [7:0] green,
                            input logic [7:0] red);
    while (gaps_enabled && $urandom_range(99) < 13) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_col   = col;
    in_row   = row;
    in_blue  = blue;
    in_green = green;
    in_red   = red;
    do @(posedge clk); while (!in_ready);
    shade_sb.note_pixel(col, row, blue, green, red);
  endtask

  // Setup cycle, then access cycle; the write lands at the access edge.
  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = addr;
    cfg_pwdata  = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == NIB_SIZE_ADDR) shade_sb.write_size(data);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  // Reads the brush size back and compares it with the predicted register.
  task automatic cfg_check_size();
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = NIB_SIZE_ADDR;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== 32'(shade_sb.nib_size)) begin
      $display("%0t ns: nib_size readback mismatch, expected %0d, actual %0d",
               $time, shade_sb.nib_size, cfg_prdata);
      shade_sb.errors++;
    end
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  // Every word yields a pixel, so an empty queue means the pipeline is empty;
  // the short pause after it also catches any stray extra output.
  task automatic wait_drained();
    while (shade_sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Lowers valid right after the last accepted word, lets the block empty,
  // then writes a register and reads the brush size back.
  task automatic reconfigure(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    in_valid = 1'b0;
    wait_drained();
    cfg_write(addr, data);
    cfg_check_size();
  endtask

  // A batch of random pixels at one brush size. Most land inside the brush
  // image, where the coverage ramp lives; the rest roam the whole byte range.
  // When hold is set, the receiver's long hold-off starts together with the
  // first words of the batch.
  task automatic run_random(input logic [31:0] size_word, input int words,
                            input bit hold);
    int          reach;
    logic [7:0]  col;
    logic [7:0]  row;
    reconfigure(NIB_SIZE_ADDR, size_word);
    if (hold) hold_off = 1'b1;
    reach = (shade_sb.nib_size == 0) ? 1 : int'(shade_sb.nib_size);
    for (int n = 0; n < words; n++) begin
      if ($urandom_range(99) < 80) begin
        col = 8'($urandom_range(reach - 1));
        row = 8'($urandom_range(reach - 1));
      end else begin
        col = 8'($urandom_range(254));
        row = 8'($urandom_range(254));
      end
      send_pixel(col, row, pick_shade(), pick_shade(), pick_shade());
    end
  endtask

  // Receiver: random back-pressure, or one long hold-off when asked for.
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_off = 1'b0;
      end else begin
        out_ready = !(gaps_enabled && $urandom_range(99) < 13);
      end
    end
  end

  // Results are sampled at the rising edge, before the block updates.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      shade_sb.check_pixel({out_blue, out_green, out_red, out_coverage});
    end
  end

  // Watchdog: gives up once nothing has moved on any port for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    do begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_psel && cfg_penable)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end while (quiet < STALL_LIMIT);
    $display("%0t ns: no progress for %0d cycles", $time, quiet);
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] size_words [12];
    shade_sb    = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_col      = '0;
    in_row      = '0;
    in_blue     = '0;
    in_green    = '0;
    in_red      = '0;
    out_ready   = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // The brush size must come out of reset at 16.
    cfg_check_size();

    // Directed words at the reset size: the centre, the corners, the edges,
    // pixels outside the image, and empty and full colors.
    send_pixel(8'd8,   8'd8,   8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'd0,   8'd0,   8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'd15,  8'd15,  8'hFF, 8'h80, 8'h01);
    send_pixel(8'd8,   8'd0,   8'hAA, 8'h55, 8'hFF);
    send_pixel(8'd0,   8'd8,   8'h55, 8'hAA, 8'h7F);
    send_pixel(8'd254, 8'd254, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'd200, 8'd3,   8'hFE, 8'h01, 8'h80);
    send_pixel(8'd3,   8'd200, 8'h80, 8'hFE, 8'h01);
    send_pixel(8'd8,   8'd8,   8'h00, 8'h00, 8'h00);
    send_pixel(8'd7,   8'd9,   8'h80, 8'h01, 8'hFE);

    // Size one: half is zero, so the distance is taken as zero everywhere.
    reconfigure(NIB_SIZE_ADDR, 32'd1);
    send_pixel(8'd0,   8'd0,   8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'd254, 8'd254, 8'hFF, 8'h7F, 8'h01);

    // Size zero behaves the same way.
    reconfigure(NIB_SIZE_ADDR, 32'd0);
    send_pixel(8'd0,   8'd0,   8'h01, 8'hFF, 8'h80);
    send_pixel(8'd254, 8'd0,   8'hFF, 8'hFF, 8'hFF);

    // Largest brush: the longest distances the squares can reach.
    reconfigure(NIB_SIZE_ADDR, 32'd255);
    send_pixel(8'd127, 8'd127, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'd0,   8'd0,   8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'd254, 8'd254, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'd0,   8'd127, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'd127, 8'd0,   8'hFF, 8'hFF, 8'hFF);

    // Smallest brush with a real centre, and a pixel far outside it.
    reconfigure(NIB_SIZE_ADDR, 32'd2);
    send_pixel(8'd1,   8'd1,   8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'd0,   8'd0,   8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'd254, 8'd1,   8'hFF, 8'hFF, 8'hFF);

    // A write past the register list must leave the brush size alone.
    reconfigure(SPARE_ADDR, 32'd5);
    send_pixel(8'd0,   8'd0,   8'hFF, 8'hFF, 8'hFF);

    // Random part. The upper bits of the data word must be ignored, so some
    // sizes carry junk above the low byte.
    size_words = '{32'd255, 32'd1, 32'd0, 32'd2, 32'd3, 32'd254, 32'd16,
                   32'd128, 32'd7, 32'hFFFF_FF40, $urandom, $urandom};
    for (int p = 0; p < 12; p++) begin
      // One batch runs with no gaps at all on either side.
      gaps_enabled = (p != 3);
      // In another, the receiver stalls long while words keep coming.
      run_random(size_words[p], PHASE_WORDS, p == 5);
    end

    @(negedge clk);
    in_valid = 1'b0;
    wait_drained();

    if (shade_sb.errors == 0 && shade_sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
